/* rtl/sstl_pkg.sv */
package sstl_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 1024;
  localparam int unsigned SAMPLE_W        = 32;
  localparam int unsigned OUT_TDATA_W     = 8;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef enum logic [1:0] {
    SEL_HOLD,
    SEL_CURSOR,
    SEL_ZERO,
    SEL_NEXT
  } idx_sel_t;

  typedef struct packed {
    logic     append;
    logic     capture;
    idx_sel_t sel;
    logic     hit;
    logic     finish;
    logic     finish_sync;
    logic     finish_full;
    logic     push_held;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic trivial;
    logic start_ok;
    logic eq;
    logic gt;
    logic last;
    logic out_free;
  } stat_t;

endpackage

/* rtl/sstl_ctrl.sv */
module sstl_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  input  logic           in_op,
  input  sstl_pkg::stat_t stat,
  output logic           in_tready,
  output sstl_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CUR,
    ST_SCAN,
    ST_HOLD
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   step_done;
  logic   step_sync;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    step_done = stat.eq || stat.gt || stat.last;
    step_sync = stat.eq;
    cmd       = '0;
    cmd.sel   = sstl_pkg::SEL_HOLD;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_op == sstl_pkg::OP_APPEND) begin
            cmd.append      = 1'b1;
            cmd.finish      = 1'b1;
            cmd.finish_full = stat.full;
            state_nxt       = stat.out_free ? ST_IDLE : ST_HOLD;
          end else if (stat.trivial) begin
            cmd.finish = 1'b1;
            state_nxt  = stat.out_free ? ST_IDLE : ST_HOLD;
          end else begin
            cmd.capture = 1'b1;
            cmd.sel     = sstl_pkg::SEL_CURSOR;
            state_nxt   = ST_CUR;
          end
        end
      end
      ST_CUR, ST_SCAN: begin
        if (state_r == ST_CUR && !stat.start_ok) begin
          cmd.sel   = sstl_pkg::SEL_ZERO;
          state_nxt = ST_SCAN;
        end else if (step_done) begin
          cmd.hit         = step_sync;
          cmd.finish      = 1'b1;
          cmd.finish_sync = step_sync;
          state_nxt       = stat.out_free ? ST_IDLE : ST_HOLD;
        end else begin
          cmd.sel   = sstl_pkg::SEL_NEXT;
          state_nxt = ST_SCAN;
        end
      end
      ST_HOLD: begin
        if (stat.out_free) begin
          cmd.push_held = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/sstl_dpath.sv */
module sstl_dpath #(
  parameter int unsigned MAX_ENTRIES = sstl_pkg::MAX_ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [sstl_pkg::SAMPLE_W-1:0]    in_sample,
  input  sstl_pkg::cmd_t                   cmd,
  output sstl_pkg::stat_t                  stat,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [sstl_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);

  logic [sstl_pkg::SAMPLE_W-1:0] mem [MAX_ENTRIES];
  logic [sstl_pkg::SAMPLE_W-1:0] rd_data_r;
  logic [sstl_pkg::SAMPLE_W-1:0] sample_r;
  logic [CNT_W-1:0]              count_r;
  logic [IDX_W-1:0]              cursor_r;
  logic [IDX_W-1:0]              idx_r;
  logic [IDX_W-1:0]              idx_nxt;
  logic [CNT_W-1:0]              idx_inc;
  logic                          held_sync_r;
  logic                          held_full_r;
  logic                          out_valid_r;
  logic                          out_sync_r;
  logic                          out_full_r;
  logic                          wr_en;

  assign idx_inc = CNT_W'(idx_r) + CNT_W'(1);

  always_comb begin
    unique case (cmd.sel)
      sstl_pkg::SEL_HOLD:   idx_nxt = idx_r;
      sstl_pkg::SEL_CURSOR: idx_nxt = cursor_r;
      sstl_pkg::SEL_ZERO:   idx_nxt = '0;
      sstl_pkg::SEL_NEXT:   idx_nxt = idx_inc[IDX_W-1:0];
      default:              idx_nxt = idx_r;
    endcase
  end

  always_comb begin
    stat.full     = (count_r == CNT_W'(MAX_ENTRIES));
    stat.trivial  = (in_sample == '0) || (count_r == '0);
    stat.start_ok = (CNT_W'(cursor_r) < count_r) && (rd_data_r <= sample_r);
    stat.eq       = (rd_data_r == sample_r);
    stat.gt       = (rd_data_r > sample_r);
    stat.last     = (idx_inc >= count_r);
    stat.out_free = !out_valid_r || out_tready;
  end

  assign wr_en = cmd.append && !stat.full;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[IDX_W-1:0]] <= in_sample;
    end
    rd_data_r <= mem[idx_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cursor_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (cmd.hit) begin
        cursor_r <= idx_r;
      end
      if ((cmd.finish && stat.out_free) || cmd.push_held) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.capture) begin
      sample_r <= in_sample;
    end
    if (cmd.finish && !stat.out_free) begin
      held_sync_r <= cmd.finish_sync;
      held_full_r <= cmd.finish_full;
    end
    if (cmd.finish && stat.out_free) begin
      out_sync_r <= cmd.finish_sync;
      out_full_r <= cmd.finish_full;
    end else if (cmd.push_held) begin
      out_sync_r <= held_sync_r;
      out_full_r <= held_full_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(sstl_pkg::OUT_TDATA_W - 2){1'b0}}, out_full_r, out_sync_r};

endmodule

/* rtl/sync_sample_table_lookup_top.sv */
// Sync-sample table lookup.
// Input stream: in_tuser carries the operation (0 append, 1 query), in_tdata the
// 32-bit sample number. Every input transaction yields exactly one output
// transaction on out_tdata: bit 0 is_sync, bit 1 table_full, bits 7:2 zero.
// An append writes the sample after the last entry, or flags table_full when
// MAX_ENTRIES entries are held. A query scans the table from the remembered
// cursor (or from entry zero) one entry per cycle through the single read port
// of the table memory, and moves the cursor to a matching entry.
// Appends, sample zero and empty-table queries finish straight from idle; other
// queries read the cursor entry, then step through the table, restarting at
// entry zero when the cursor entry exceeds the sample. The next item is taken
// the cycle after a result is registered, so items are handled one at a time.
// A registered output stage holds one result; while it waits, one more item is
// taken and processed, and its result is held until the receiver takes the first.
// Reset (rst_n low, synchronous) empties the table and clears the cursor and the
// output valid; table contents are not cleared.
module sync_sample_table_lookup_top #(
  parameter int unsigned MAX_ENTRIES = sstl_pkg::MAX_ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [sstl_pkg::SAMPLE_W-1:0]    in_tdata,   // sample_number
  input  logic                             in_tuser,   // operation
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [sstl_pkg::OUT_TDATA_W-1:0] out_tdata   // is_sync, table_full
);

  sstl_pkg::cmd_t  cmd;
  sstl_pkg::stat_t stat;

  sstl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_op     (in_tuser),
    .stat      (stat),
    .in_tready (in_tready),
    .cmd       (cmd)
  );

  sstl_dpath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_sample  (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

/* rtl/sstl_checker.sv */
module sstl_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [sstl_pkg::SAMPLE_W-1:0]    in_tdata,
  input logic                             in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [sstl_pkg::OUT_TDATA_W-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output dropped or changed while stalled");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("is_sync and table_full both set");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[sstl_pkg::OUT_TDATA_W-1:2] == '0))
    else $error("output padding not zero");

  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_zero_query: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == sstl_pkg::OP_QUERY) && (in_tdata == '0) &&
      !out_tvalid |=> out_tvalid && !out_tdata[0])
    else $error("sample zero reported as sync");

endmodule

bind sync_sample_table_lookup_top sstl_checker u_sstl_checker (.*);

/* verif/sync_sample_table_lookup_checker.sv */
`timescale 1ns / 100ps
module sync_sample_table_lookup_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [sstl_pkg::SAMPLE_W-1:0]    in_tdata,   // sample_number
  input  logic                             in_tuser,   // operation
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [sstl_pkg::OUT_TDATA_W-1:0] out_tdata,  // is_sync, table_full
  output int                               mismatches,
  output int                               awaited
);

  localparam int unsigned TABLE_DEPTH = sstl_pkg::MAX_ENTRIES_DEF;

  typedef struct packed {
    logic is_sync;
    logic table_full;
  } lookup_res_t;

  lookup_res_t                    pending_answers [$];
  logic [sstl_pkg::SAMPLE_W-1:0]  sync_list [TABLE_DEPTH];
  int unsigned                    list_len = 0;
  int unsigned                    hit_pos  = 0;
  int                             bad_count = 0;

  function automatic logic sample_in_list(input logic [sstl_pkg::SAMPLE_W-1:0] smp);
    int unsigned pos;
    pos = 0;
    if (smp == '0 || list_len == 0) return 1'b0;
    if (hit_pos < list_len && sync_list[hit_pos] <= smp) pos = hit_pos;
    while (pos < list_len && sync_list[pos] <= smp) begin
      if (sync_list[pos] == smp) begin
        hit_pos = pos;
        return 1'b1;
      end
      pos++;
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin : watch
    lookup_res_t got;
    lookup_res_t want;
    if (!rst_n) begin
      pending_answers.delete();
      list_len  = 0;
      hit_pos   = 0;
      bad_count = 0;
      mismatches <= 0;
      awaited    <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.is_sync    = out_tdata[0];
        got.table_full = out_tdata[1];
        if (pending_answers.size() == 0) begin
          bad_count++;
          if (bad_count <= 10)
            $display("%0t: unexpected result is_sync=%0b table_full=%0b",
                     $time, got.is_sync, got.table_full);
        end else begin
          want = pending_answers.pop_front();
          if (got.is_sync !== want.is_sync || got.table_full !== want.table_full) begin
            bad_count++;
            if (bad_count <= 10)
              $display("%0t: expected sync=%0b full=%0b, got sync=%0b full=%0b",
                       $time, want.is_sync, want.table_full, got.is_sync, got.table_full);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        want = '0;
        if (in_tuser == sstl_pkg::OP_APPEND) begin
          if (list_len < TABLE_DEPTH) begin
            sync_list[list_len] = in_tdata;
            list_len++;
          end else begin
            want.table_full = 1'b1;
          end
        end else begin
          want.is_sync = sample_in_list(in_tdata);
        end
        pending_answers.push_back(want);
      end
      mismatches <= bad_count;
      awaited    <= pending_answers.size();
    end
  end

endmodule

/* verif/sync_sample_table_lookup_top_test.sv */
`timescale 1ns / 100ps
module sync_sample_table_lookup_top_test;

  localparam int unsigned TABLE_DEPTH = sstl_pkg::MAX_ENTRIES_DEF;

  logic                             clk        = 1'b0;
  logic                             rst_n      = 1'b0;
  logic                             in_tvalid  = 1'b0;
  logic                             in_tready;
  logic [sstl_pkg::SAMPLE_W-1:0]    in_tdata   = '0;   // sample_number
  logic                             in_tuser   = 1'b0; // operation
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [sstl_pkg::OUT_TDATA_W-1:0] out_tdata;         // is_sync, table_full

  int          mismatches;
  int          awaited;
  int unsigned src_idle_pct  = 23;
  int unsigned sink_idle_pct = 55;
  logic [31:0] pushed_vals [TABLE_DEPTH];
  int unsigned pushed_len   = 0;
  int unsigned appends_sent = 0;

  always #5 clk = ~clk;

  sync_sample_table_lookup_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  sync_sample_table_lookup_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .mismatches (mismatches),
    .awaited    (awaited)
  );

  always @(negedge clk) out_tready <= ($urandom_range(0, 99) >= sink_idle_pct);

  task automatic send_item(input logic op, input logic [31:0] smp);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= smp;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    if (op == sstl_pkg::OP_APPEND) begin
      appends_sent++;
      if (pushed_len < TABLE_DEPTH) begin
        pushed_vals[pushed_len] = smp;
        pushed_len++;
      end
    end
  endtask

  initial begin : stimulus
    int unsigned r;
    int unsigned qptr;
    int unsigned rnd_items;
    int unsigned hi;
    logic [32:0] sum;
    logic [31:0] run_top;
    logic [31:0] smp;
    logic        op;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty table, then a short ascending table
    send_item(sstl_pkg::OP_QUERY,  32'd5);
    send_item(sstl_pkg::OP_QUERY,  32'd0);
    send_item(sstl_pkg::OP_QUERY,  32'hFFFF_FFFF);
    send_item(sstl_pkg::OP_APPEND, 32'd3);
    send_item(sstl_pkg::OP_APPEND, 32'd7);
    send_item(sstl_pkg::OP_APPEND, 32'd10);
    send_item(sstl_pkg::OP_QUERY,  32'd0);
    send_item(sstl_pkg::OP_QUERY,  32'd7);
    send_item(sstl_pkg::OP_QUERY,  32'd10);
    send_item(sstl_pkg::OP_QUERY,  32'd3);
    send_item(sstl_pkg::OP_QUERY,  32'd8);
    send_item(sstl_pkg::OP_QUERY,  32'hFFFF_FFFF);
    // out of order entry
    send_item(sstl_pkg::OP_APPEND, 32'd5);
    send_item(sstl_pkg::OP_QUERY,  32'd5);
    send_item(sstl_pkg::OP_APPEND, 32'd12);
    send_item(sstl_pkg::OP_QUERY,  32'd12);
    send_item(sstl_pkg::OP_QUERY,  32'd11);
    send_item(sstl_pkg::OP_QUERY,  32'd1);

    run_top   = 32'd12;
    qptr      = 0;
    rnd_items = 0;
    while (rnd_items < 1100 || appends_sent < TABLE_DEPTH + 24) begin
      if (rnd_items == 400) begin
        src_idle_pct  = 55;
        sink_idle_pct = 23;
      end else if (rnd_items == 800) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      r  = $urandom_range(0, 99);
      op = (r < ((pushed_len < TABLE_DEPTH) ? 92 : 50)) ? sstl_pkg::OP_APPEND
                                                        : sstl_pkg::OP_QUERY;
      if (op == sstl_pkg::OP_APPEND) begin
        r = $urandom_range(0, 99);
        if (pushed_len >= TABLE_DEPTH) begin
          smp = $urandom;
        end else if (r < 4) begin
          smp = $urandom_range(0, run_top);
        end else begin
          sum = {1'b0, run_top} + ((r < 7) ? $urandom_range(1, 32'h07FF_FFFF)
                                           : $urandom_range(1, 48));
          if (sum[32]) begin
            smp = $urandom_range(0, run_top);
          end else begin
            run_top = sum[31:0];
            smp     = run_top;
          end
        end
      end else begin
        hi = pushed_len - 1;
        r  = $urandom_range(0, 99);
        if (r < 45) begin
          qptr = qptr + $urandom_range(0, 3);
          if (qptr > hi) qptr = hi;
          smp = pushed_vals[qptr];
        end else if (r < 60) begin
          smp = pushed_vals[qptr] + $urandom_range(1, 3);
        end else if (r < 70) begin
          qptr = $urandom_range(0, (hi < 20) ? hi : 20);
          smp  = pushed_vals[qptr];
        end else if (r < 75) begin
          smp = '0;
        end else if (r < 82) begin
          smp = $urandom;
        end else if (r < 88) begin
          qptr = $urandom_range(0, hi);
          smp  = pushed_vals[qptr];
        end else begin
          smp = pushed_vals[hi];
        end
      end
      send_item(op, smp);
      rnd_items++;
    end
    in_tvalid <= 1'b0;

    do @(posedge clk); while (awaited != 0);
    repeat (1100) @(posedge clk);
    if (mismatches == 0 && awaited == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  initial begin : watchdog
    #60_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
